// ----- hdl/sudiv_pkg.sv -----
// shared types and constants for the pipelined 32-bit signed/unsigned divider
// no dependencies; imported by every divider module

package sudiv_pkg;

   // operand and result word width
   localparam int WORD_WIDTH = 32;

   // default number of quotient bits resolved in each pipeline stage
   localparam int STEPS_PER_STAGE_DEFAULT = 2;

   // opcode encodings
   localparam logic OP_SIGNED   = 1'b0;
   localparam logic OP_UNSIGNED = 1'b1;

   // state of one request as it moves down the divide pipeline
   typedef struct packed {
      logic [WORD_WIDTH-1:0] rem;    // partial remainder
      logic [WORD_WIDTH-1:0] dq;     // dividend bits shifting out, quotient bits shifting in
      logic [WORD_WIDTH-1:0] dmag;   // divisor magnitude
      logic                  neg_q;  // negate quotient at the end
      logic                  neg_r;  // negate remainder at the end
   } work_type;

endpackage

// ----- hdl/sudiv_pre.sv -----
// input stage of the divider: takes operand magnitudes and records result signs
// depends on sudiv_pkg

module sudiv_pre (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   input  logic                            opcode,
   input  logic [sudiv_pkg::WORD_WIDTH-1:0] dividend,
   input  logic [sudiv_pkg::WORD_WIDTH-1:0] divisor,
   output logic                            out_valid,
   output sudiv_pkg::work_type             out_work
);
   import sudiv_pkg::*;

   logic     n_neg;
   logic     d_neg;
   logic     valid_ff;
   logic     valid_in;
   work_type work_ff;
   work_type work_in;

   // sign handling; a zero divisor falls out of the array with the right answer
   always_comb begin
      n_neg         = (opcode == OP_SIGNED) && dividend[WORD_WIDTH-1];
      d_neg         = (opcode == OP_SIGNED) && divisor[WORD_WIDTH-1];
      valid_in      = in_valid;
      work_in.rem   = '0;
      work_in.dq    = n_neg ? (~dividend + WORD_WIDTH'(1)) : dividend;
      work_in.dmag  = d_neg ? (~divisor + WORD_WIDTH'(1)) : divisor;
      work_in.neg_q = n_neg ^ d_neg;
      work_in.neg_r = n_neg;
   end

   // valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      work_ff <= work_in;
   end

   assign out_valid = valid_ff;
   assign out_work  = work_ff;

endmodule

// ----- hdl/sudiv_stage.sv -----
// one pipeline stage of the restoring divide array, resolving STEPS quotient bits
// depends on sudiv_pkg

module sudiv_stage #(
   parameter int STEPS = sudiv_pkg::STEPS_PER_STAGE_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  sudiv_pkg::work_type in_work,
   output logic                out_valid,
   output sudiv_pkg::work_type out_work
);
   import sudiv_pkg::*;

   logic [WORD_WIDTH-1:0] rem;
   logic [WORD_WIDTH-1:0] dq;
   logic [WORD_WIDTH:0]   trial;
   logic                  valid_ff;
   logic                  valid_in;
   work_type              work_ff;
   work_type              work_in;

   // restoring shift-subtract steps
   always_comb begin
      rem   = in_work.rem;
      dq    = in_work.dq;
      trial = '0;
      for (int k = 0; k < STEPS; k++) begin
         trial = {rem, dq[WORD_WIDTH-1]} - {1'b0, in_work.dmag};
         if (!trial[WORD_WIDTH]) begin
            rem = trial[WORD_WIDTH-1:0];
            dq  = {dq[WORD_WIDTH-2:0], 1'b1};
         end else begin
            rem = {rem[WORD_WIDTH-2:0], dq[WORD_WIDTH-1]};
            dq  = {dq[WORD_WIDTH-2:0], 1'b0};
         end
      end
      valid_in      = in_valid;
      work_in       = in_work;
      work_in.rem   = rem;
      work_in.dq    = dq;
   end

   // valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      work_ff <= work_in;
   end

   assign out_valid = valid_ff;
   assign out_work  = work_ff;

endmodule

// ----- hdl/sudiv_post.sv -----
// output stage of the divider: applies result signs and registers the response
// depends on sudiv_pkg

module sudiv_post (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   input  sudiv_pkg::work_type              in_work,
   output logic                             out_strobe,
   output logic [sudiv_pkg::WORD_WIDTH-1:0] out_quotient,
   output logic [sudiv_pkg::WORD_WIDTH-1:0] out_remainder
);
   import sudiv_pkg::*;

   logic                  strobe_ff;
   logic                  strobe_in;
   logic [WORD_WIDTH-1:0] quotient_ff;
   logic [WORD_WIDTH-1:0] quotient_in;
   logic [WORD_WIDTH-1:0] remainder_ff;
   logic [WORD_WIDTH-1:0] remainder_in;

   // sign fix-up; also yields the fixed divide-by-zero and overflow answers
   always_comb begin
      strobe_in    = in_valid;
      quotient_in  = in_work.neg_q ? (~in_work.dq + WORD_WIDTH'(1)) : in_work.dq;
      remainder_in = in_work.neg_r ? (~in_work.rem + WORD_WIDTH'(1)) : in_work.rem;
   end

   // response strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= strobe_in;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      quotient_ff  <= quotient_in;
      remainder_ff <= remainder_in;
   end

   assign out_strobe    = strobe_ff;
   assign out_quotient  = quotient_ff;
   assign out_remainder = remainder_ff;

endmodule

// ----- hdl/signed_unsigned_divider_32_unit.sv -----
// Pipelined 32-bit divider with signed and unsigned modes and defined results for
// divide by zero and signed overflow, no traps. A request is taken in every cycle
// (busy stays low) and its response appears on rsp_strobe after passing through the
// restoring divide array: one input stage, 32/STEPS_PER_STAGE array stages, one
// output stage. Responses come out in request order and are shown for one cycle
// only; the receiver cannot stall them. STEPS_PER_STAGE must divide 32.
// Depends on sudiv_pkg, sudiv_pre, sudiv_stage and sudiv_post.

module signed_unsigned_divider_32_unit #(
   parameter int STEPS_PER_STAGE = sudiv_pkg::STEPS_PER_STAGE_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic                             req_opcode,
   input  logic [sudiv_pkg::WORD_WIDTH-1:0] req_dividend,
   input  logic [sudiv_pkg::WORD_WIDTH-1:0] req_divisor,
   output logic                             rsp_strobe,
   output logic [sudiv_pkg::WORD_WIDTH-1:0] rsp_quotient,
   output logic [sudiv_pkg::WORD_WIDTH-1:0] rsp_remainder
);
   import sudiv_pkg::*;

   localparam int NUM_STAGES = WORD_WIDTH / STEPS_PER_STAGE;
   localparam int LATENCY    = NUM_STAGES + 2;

   logic     accept;
   logic     pipe_valid [NUM_STAGES+1];
   work_type pipe_work  [NUM_STAGES+1];

   // fully pipelined, so a request is always taken
   assign busy   = 1'b0;
   assign accept = start && !busy;

   // operand magnitudes and signs
   sudiv_pre u_pre (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .opcode    (req_opcode),
      .dividend  (req_dividend),
      .divisor   (req_divisor),
      .out_valid (pipe_valid[0]),
      .out_work  (pipe_work[0])
   );

   // divide array
   for (genvar s = 0; s < NUM_STAGES; s++) begin : g_stage
      sudiv_stage #(
         .STEPS (STEPS_PER_STAGE)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (pipe_valid[s]),
         .in_work   (pipe_work[s]),
         .out_valid (pipe_valid[s+1]),
         .out_work  (pipe_work[s+1])
      );
   end

   // sign fix-up and response register
   sudiv_post u_post (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (pipe_valid[NUM_STAGES]),
      .in_work       (pipe_work[NUM_STAGES]),
      .out_strobe    (rsp_strobe),
      .out_quotient  (rsp_quotient),
      .out_remainder (rsp_remainder)
   );

`ifndef SYNTHESIS
   // every request produces a response once it has passed the whole pipeline
   a_latency_fwd: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##LATENCY rsp_strobe)
      else $error("request did not produce a response on time");

   // no response without a request at the matching cycle
   a_latency_back: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, LATENCY))
      else $error("response without a matching request");

   // unsigned divide with nonzero divisor leaves a remainder below the divisor
   a_unsigned_rem: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && ($past(req_opcode, LATENCY) == OP_UNSIGNED)
         && ($past(req_divisor, LATENCY) != '0))
      |-> (rsp_remainder < $past(req_divisor, LATENCY)))
      else $error("unsigned remainder not below divisor");
`endif

endmodule

// ----- tb/sudiv_result_check.sv -----
// result checker for the pipelined 32-bit divider: predicts quotient and remainder
// for every accepted request and compares each strobed response in order
// depends on sudiv_pkg

module sudiv_result_check (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic                             busy,
   input  logic                             req_opcode,
   input  logic [sudiv_pkg::WORD_WIDTH-1:0] req_dividend,
   input  logic [sudiv_pkg::WORD_WIDTH-1:0] req_divisor,
   input  logic                             rsp_strobe,
   input  logic [sudiv_pkg::WORD_WIDTH-1:0] rsp_quotient,
   input  logic [sudiv_pkg::WORD_WIDTH-1:0] rsp_remainder,
   output int                               fail_count,
   output int                               pending
);
   import sudiv_pkg::*;

   typedef logic [WORD_WIDTH-1:0] word_type;

   typedef struct packed {
      word_type quotient;
      word_type remainder;
   } div_result_type;

   localparam word_type MIN_WORD = {1'b1, {(WORD_WIDTH-1){1'b0}}};
   localparam word_type ALL_ONES = '1;
   localparam word_type WORD_ONE = 1;

   // quotient and remainder waiting for their responses, oldest first
   div_result_type quot_rem_q[$];

   // quotient and remainder with defined results for zero divisor and overflow
   function automatic div_result_type divide_words(logic op, word_type num, word_type den);
      div_result_type res;
      logic           num_neg;
      logic           den_neg;
      word_type       num_mag;
      word_type       den_mag;
      word_type       q_mag;
      word_type       r_mag;
      num_neg = num[WORD_WIDTH-1];
      den_neg = den[WORD_WIDTH-1];
      if (op == OP_UNSIGNED) begin
         if (den == '0) begin
            res.quotient  = ALL_ONES;
            res.remainder = num;
         end else begin
            res.quotient  = num / den;
            res.remainder = num % den;
         end
      end else if (den == '0) begin
         res.quotient  = num_neg ? WORD_ONE : ALL_ONES;
         res.remainder = num;
      end else if (num == MIN_WORD && den == ALL_ONES) begin
         res.quotient  = MIN_WORD;
         res.remainder = '0;
      end else begin
         // divide magnitudes, then restore signs: truncation toward zero
         num_mag = num_neg ? -num : num;
         den_mag = den_neg ? -den : den;
         q_mag   = num_mag / den_mag;
         r_mag   = num_mag % den_mag;
         res.quotient  = (num_neg != den_neg) ? -q_mag : q_mag;
         res.remainder = num_neg ? -r_mag : r_mag;
      end
      return res;
   endfunction

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   // compare responses, then queue the prediction for a newly accepted request
   always @(posedge clock) begin
      div_result_type want;
      if (!reset) begin
         if (rsp_strobe === 1'b1) begin
            if (quot_rem_q.size() == 0) begin
               $error("response with no request outstanding: quotient %h remainder %h",
                      rsp_quotient, rsp_remainder);
               fail_count++;
            end else begin
               want = quot_rem_q.pop_front();
               if (rsp_quotient !== want.quotient) begin
                  $error("quotient mismatch: expected %h, actual %h",
                         want.quotient, rsp_quotient);
                  fail_count++;
               end
               if (rsp_remainder !== want.remainder) begin
                  $error("remainder mismatch: expected %h, actual %h",
                         want.remainder, rsp_remainder);
                  fail_count++;
               end
            end
         end
         if (start && !busy)
            quot_rem_q.push_back(divide_words(req_opcode, req_dividend, req_divisor));
      end
      pending = quot_rem_q.size();
   end

endmodule

// ----- tb/signed_unsigned_divider_32_unit_tb.sv -----
// testbench top for the pipelined 32-bit divider: drives directed and random
// divide requests with varying idle gaps and reports the verdict
// depends on sudiv_pkg, sudiv_result_check and the divider rtl

module signed_unsigned_divider_32_unit_tb;
   import sudiv_pkg::*;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int RANDOM_COUNT  = 1400;
   localparam int DRAIN_CYCLES  = 40;
   localparam logic [WORD_WIDTH-1:0] MIN_WORD = {1'b1, {(WORD_WIDTH-1){1'b0}}};
   localparam logic [WORD_WIDTH-1:0] ALL_ONES = '1;

   logic                  clock;
   logic                  reset        = 1'b1;
   logic                  start        = 1'b0;
   logic                  req_opcode   = OP_SIGNED;
   logic [WORD_WIDTH-1:0] req_dividend = '0;
   logic [WORD_WIDTH-1:0] req_divisor  = '0;
   logic                  busy;
   logic                  rsp_strobe;
   logic [WORD_WIDTH-1:0] rsp_quotient;
   logic [WORD_WIDTH-1:0] rsp_remainder;
   int                    fail_count;
   int                    pending;
   int                    cycle_count;
   int                    idle_pct;

   // clock, period 4
   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   signed_unsigned_divider_32_unit uut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_opcode    (req_opcode),
      .req_dividend  (req_dividend),
      .req_divisor   (req_divisor),
      .rsp_strobe    (rsp_strobe),
      .rsp_quotient  (rsp_quotient),
      .rsp_remainder (rsp_remainder)
   );

   sudiv_result_check result_check (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_opcode    (req_opcode),
      .req_dividend  (req_dividend),
      .req_divisor   (req_divisor),
      .rsp_strobe    (rsp_strobe),
      .rsp_quotient  (rsp_quotient),
      .rsp_remainder (rsp_remainder),
      .fail_count    (fail_count),
      .pending       (pending)
   );

   // run limit
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("TB_ERROR");
      $finish;
   end

   // issue one divide request, with random idle cycles ahead of it
   task automatic send_divide(input logic op, input logic [WORD_WIDTH-1:0] num,
                              input logic [WORD_WIDTH-1:0] den);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start        <= 1'b1;
      req_opcode   <= op;
      req_dividend <= num;
      req_divisor  <= den;
      @(posedge clock);
      while (busy)
         @(posedge clock);
   endtask

   // random request shaped to hit sign combinations, zero divisors,
   // overflow and quotient boundaries
   task automatic send_random_divide();
      logic [WORD_WIDTH-1:0] num;
      logic [WORD_WIDTH-1:0] den;
      logic                  op;
      op  = 1'($urandom_range(1));
      num = $urandom;
      den = $urandom;
      case ($urandom_range(9))
         0, 1: ;
         2, 3: begin
            num = num >> $urandom_range(WORD_WIDTH-1);
            den = den >> $urandom_range(WORD_WIDTH-1);
            if ($urandom_range(1)) num = -num;
            if ($urandom_range(1)) den = -den;
         end
         4: begin
            den = $urandom_range(1, 15);
            if ($urandom_range(1)) den = -den;
         end
         5: den = '0;
         6: begin
            num = MIN_WORD;
            case ($urandom_range(2))
               0: den = ALL_ONES;
               1: den = 1;
               default: ;
            endcase
         end
         7: begin
            den = den >> $urandom_range(WORD_WIDTH-1);
            num = den * $urandom_range(0, 3) + $urandom_range(0, 2);
         end
         8: begin
            num = $urandom_range(255);
            den = $urandom_range(255);
            if ($urandom_range(1)) num = -num;
            if ($urandom_range(1)) den = -den;
         end
         default: den = num + $urandom_range(0, 2) - 1;
      endcase
      send_divide(op, num, den);
   endtask

   // stimulus and verdict
   initial begin
      idle_pct = 16;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // signed divide by zero, both dividend signs
      send_divide(OP_SIGNED, 32'd0, 32'd0);
      send_divide(OP_SIGNED, 32'h7FFF_FFFF, 32'd0);
      send_divide(OP_SIGNED, MIN_WORD, 32'd0);
      send_divide(OP_SIGNED, ALL_ONES, 32'd0);
      // signed overflow and neighbors
      send_divide(OP_SIGNED, MIN_WORD, ALL_ONES);
      send_divide(OP_SIGNED, MIN_WORD, 32'd1);
      send_divide(OP_SIGNED, 32'h7FFF_FFFF, ALL_ONES);
      // truncation toward zero, remainder follows dividend sign
      send_divide(OP_SIGNED, -32'sd7, 32'd2);
      send_divide(OP_SIGNED, 32'd7, -32'sd2);
      send_divide(OP_SIGNED, -32'sd7, -32'sd2);
      send_divide(OP_SIGNED, 32'd0, 32'd5);
      send_divide(OP_SIGNED, ALL_ONES, ALL_ONES);
      send_divide(OP_SIGNED, MIN_WORD, MIN_WORD);
      send_divide(OP_SIGNED, 32'h7FFF_FFFF, MIN_WORD);
      send_divide(OP_SIGNED, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      // unsigned divide by zero and extremes
      send_divide(OP_UNSIGNED, ALL_ONES, 32'd0);
      send_divide(OP_UNSIGNED, 32'd0, 32'd0);
      send_divide(OP_UNSIGNED, ALL_ONES, 32'd1);
      send_divide(OP_UNSIGNED, ALL_ONES, ALL_ONES);
      send_divide(OP_UNSIGNED, MIN_WORD, ALL_ONES);
      send_divide(OP_UNSIGNED, 32'hFFFF_FFFE, ALL_ONES);
      send_divide(OP_UNSIGNED, 32'd5, 32'd7);
      send_divide(OP_UNSIGNED, 32'd100, 32'd7);

      // random requests in three idle phases
      for (int i = 0; i < RANDOM_COUNT; i++) begin
         if (i == RANDOM_COUNT / 3)
            idle_pct = 55;
         else if (i == 2 * RANDOM_COUNT / 3)
            idle_pct = 0;
         send_random_divide();
      end
      start <= 1'b0;
      @(posedge clock);

      // let the pipeline drain
      while (pending != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
